[hw/rtl/srct_pkg.sv]
`default_nettype none

package srct_pkg;

   // Default geometry
   localparam int ENTRIES_DEF   = 16;
   localparam int ADDR_BITS_DEF = 48;

   // Fixed field widths
   localparam int SIZE_W   = 48;
   localparam int TID_W    = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;

   // min_size after reset
   localparam logic [SIZE_W-1:0] MIN_SIZE_RST = SIZE_W'(4096);

   // Request codes
   typedef enum logic [1:0] {
      REQ_LOOKUP  = 2'd0,
      REQ_PREPARE = 2'd1,
      REQ_ASSIGN  = 2'd2,
      REQ_RELEASE = 2'd3
   } req_kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NO_MATCH = 2'd3
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/srct_pick.sv]
`default_nettype none

// Picks the newest entry among a set of matching entries.
// Ranks of valid entries are distinct, so at most one entry wins.
module srct_pick #(
   parameter int ENTRIES = srct_pkg::ENTRIES_DEF,
   parameter int RANK_W  = 4,
   parameter int IDX_W   = 4
) (
   input  logic [ENTRIES-1:0] match_vec,
   input  logic [RANK_W-1:0]  rank [ENTRIES],
   output logic               found,
   output logic [ENTRIES-1:0] onehot,
   output logic [IDX_W-1:0]   idx
);

   // An entry wins if no other matching entry is newer (lower rank)
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         onehot[i] = match_vec[i];
         for (int j = 0; j < ENTRIES; j++) begin
            if (match_vec[j] && (rank[j] < rank[i])) begin
               onehot[i] = 1'b0;
            end
         end
      end
   end

   // Encode the winner
   always_comb begin
      idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (onehot[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
   end

   assign found = |match_vec;

endmodule

`default_nettype wire

[hw/rtl/stack_range_context_table_unit.sv]
`default_nettype none

// Stack range context table.
// Input channel: an item (req_type, req_address, req_stack_size, req_thread_id)
// is taken at a rising edge with start high and busy low. busy is high only
// while reset is asserted, so one item can be taken every cycle.
// Requests: lookup a pointer, prepare (add) a range, assign a thread id to
// the newest exact range, release the newest entry owned by a thread id.
// Result channel: every item gives one result after the input register and
// the result register, shown for one cycle with rsp_valid high. The receiver
// cannot stall; results leave at the same rate as items arrive, one per cycle.
// Each item is registered, then all entries are compared in parallel and the
// table and the result register are updated at the same edge, so the next
// item already sees the updated table.
// Configuration: csr_write_enable writes min_size, the smallest stack size
// that prepare accepts. Write it only while no item is in flight.
// Reset (synchronous) empties the table, drops any item in flight and sets
// min_size to 4096.
module stack_range_context_table_unit #(
   parameter int ENTRIES   = srct_pkg::ENTRIES_DEF,
   parameter int ADDR_BITS = srct_pkg::ADDR_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic [ADDR_BITS-1:0]        req_address,
   input  logic [srct_pkg::SIZE_W-1:0] req_stack_size,
   input  logic [srct_pkg::TID_W-1:0]  req_thread_id,
   input  logic                        csr_write_enable,
   input  logic [srct_pkg::SIZE_W-1:0] csr_write_data,
   output logic                        rsp_valid,
   output logic [srct_pkg::STATUS_W-1:0] rsp_status,
   output logic                        rsp_hit,
   output logic [srct_pkg::SLOT_W-1:0] rsp_slot,
   output logic [srct_pkg::TID_W-1:0]  rsp_owner_thread
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int SUM_W  = (ADDR_BITS > srct_pkg::SIZE_W) ? ADDR_BITS : srct_pkg::SIZE_W;

   // Input register
   logic                          req_valid_ff;
   srct_pkg::req_kind_type        req_kind_ff;
   logic [ADDR_BITS-1:0]          addr_ff;
   logic [srct_pkg::SIZE_W-1:0]   size_ff;
   logic [srct_pkg::TID_W-1:0]    tid_ff;

   // Configuration
   logic [srct_pkg::SIZE_W-1:0]   min_size_ff;

   // Table
   logic [ENTRIES-1:0]            valid_ff, valid_in;
   logic [RANK_W-1:0]             rank_ff [ENTRIES];
   logic [RANK_W-1:0]             rank_in [ENTRIES];
   logic [ADDR_BITS-1:0]          low_ff  [ENTRIES];
   logic [ADDR_BITS-1:0]          high_ff [ENTRIES];
   logic [srct_pkg::TID_W-1:0]    owner_ff [ENTRIES];
   logic [ENTRIES-1:0]            new_we, own_we;
   logic [srct_pkg::TID_W-1:0]    own_wdata;

   // Result register
   logic                          rsp_valid_ff;
   srct_pkg::status_type          status_ff, status_in;
   logic                          hit_ff, hit_in;
   logic [srct_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [srct_pkg::TID_W-1:0]    owner_out_ff, owner_out_in;

   // Compare stage signals
   logic [SUM_W-1:0]              sum_w;
   logic [ADDR_BITS-1:0]          end_addr;
   logic                          range_bad;
   logic [ENTRIES-1:0]            holds, exact, owned;
   logic                          hold_found, exact_found, own_found;
   logic [ENTRIES-1:0]            hold_onehot, exact_onehot, own_onehot;
   logic [IDX_W-1:0]              hold_idx, exact_idx, own_idx;
   logic [srct_pkg::TID_W-1:0]    hold_owner;
   logic [RANK_W-1:0]             own_rank;
   logic [ENTRIES-1:0]            free_onehot;
   logic                          free_found;
   logic [IDX_W-1:0]              free_idx;

   assign busy = reset;

   // Input register and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         min_size_ff  <= srct_pkg::MIN_SIZE_RST;
      end else begin
         req_valid_ff <= start;
         if (csr_write_enable) begin
            min_size_ff <= csr_write_data;
         end
      end
      if (start && !busy) begin
         req_kind_ff <= srct_pkg::req_kind_type'(req_type);
         addr_ff     <= req_address;
         size_ff     <= req_stack_size;
         tid_ff      <= req_thread_id;
      end
   end

   // Range end, wrapped to the address width
   assign sum_w     = SUM_W'(addr_ff) + SUM_W'(size_ff);
   assign end_addr  = sum_w[ADDR_BITS-1:0];
   assign range_bad = (addr_ff == '0) || (size_ff < min_size_ff) || (end_addr <= addr_ff);

   // Per-entry compares, all in parallel
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         holds[i] = valid_ff[i] && (addr_ff >= low_ff[i]) && (addr_ff < high_ff[i]);
         exact[i] = valid_ff[i] && (low_ff[i] == addr_ff) && (high_ff[i] == end_addr);
         owned[i] = valid_ff[i] && (tid_ff != '0) && (owner_ff[i] == tid_ff);
      end
   end

   srct_pick #(.ENTRIES(ENTRIES), .RANK_W(RANK_W), .IDX_W(IDX_W)) u_pick_hold (
      .match_vec (holds),
      .rank      (rank_ff),
      .found     (hold_found),
      .onehot    (hold_onehot),
      .idx       (hold_idx)
   );

   srct_pick #(.ENTRIES(ENTRIES), .RANK_W(RANK_W), .IDX_W(IDX_W)) u_pick_exact (
      .match_vec (exact),
      .rank      (rank_ff),
      .found     (exact_found),
      .onehot    (exact_onehot),
      .idx       (exact_idx)
   );

   srct_pick #(.ENTRIES(ENTRIES), .RANK_W(RANK_W), .IDX_W(IDX_W)) u_pick_own (
      .match_vec (owned),
      .rank      (rank_ff),
      .found     (own_found),
      .onehot    (own_onehot),
      .idx       (own_idx)
   );

   // Owner of the holding entry and rank of the released entry
   always_comb begin
      hold_owner = '0;
      own_rank   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hold_onehot[i]) begin
            hold_owner = hold_owner | owner_ff[i];
         end
         if (own_onehot[i]) begin
            own_rank = own_rank | rank_ff[i];
         end
      end
   end

   // Lowest free entry: lowest clear bit of the valid vector
   assign free_onehot = ~valid_ff & (valid_ff + ENTRIES'(1));
   assign free_found  = ~(&valid_ff);

   always_comb begin
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (free_onehot[i]) begin
            free_idx = free_idx | IDX_W'(i);
         end
      end
   end

   // Request decode: result and table update
   always_comb begin
      valid_in     = valid_ff;
      rank_in      = rank_ff;
      new_we       = '0;
      own_we       = '0;
      own_wdata    = tid_ff;
      status_in    = srct_pkg::STATUS_OK;
      hit_in       = 1'b0;
      slot_in      = '0;
      owner_out_in = '0;
      if (req_valid_ff) begin
         unique case (req_kind_ff)
            srct_pkg::REQ_LOOKUP: begin
               if (hold_found) begin
                  hit_in       = 1'b1;
                  slot_in      = srct_pkg::SLOT_W'(hold_idx);
                  owner_out_in = hold_owner;
               end
            end
            srct_pkg::REQ_PREPARE: begin
               if (range_bad) begin
                  status_in = srct_pkg::STATUS_INVALID;
               end else if (hold_found) begin
                  hit_in       = 1'b1;
                  slot_in      = srct_pkg::SLOT_W'(hold_idx);
                  owner_out_in = hold_owner;
               end else if (!free_found) begin
                  status_in = srct_pkg::STATUS_FULL;
               end else begin
                  // New entry becomes the newest; all other valid entries age by one
                  hit_in   = 1'b1;
                  slot_in  = srct_pkg::SLOT_W'(free_idx);
                  new_we   = free_onehot;
                  valid_in = valid_ff | free_onehot;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (free_onehot[i]) begin
                        rank_in[i] = '0;
                     end else if (valid_ff[i]) begin
                        rank_in[i] = rank_ff[i] + RANK_W'(1);
                     end
                  end
               end
            end
            srct_pkg::REQ_ASSIGN: begin
               if (exact_found) begin
                  own_we       = exact_onehot;
                  hit_in       = 1'b1;
                  slot_in      = srct_pkg::SLOT_W'(exact_idx);
                  owner_out_in = tid_ff;
               end else begin
                  status_in = srct_pkg::STATUS_NO_MATCH;
               end
            end
            srct_pkg::REQ_RELEASE: begin
               if (own_found) begin
                  // Free the entry and close the gap in the ages
                  valid_in     = valid_ff & ~own_onehot;
                  hit_in       = 1'b1;
                  slot_in      = srct_pkg::SLOT_W'(own_idx);
                  owner_out_in = tid_ff;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && (rank_ff[i] > own_rank)) begin
                        rank_in[i] = rank_ff[i] - RANK_W'(1);
                     end
                  end
               end else begin
                  status_in = srct_pkg::STATUS_NO_MATCH;
               end
            end
            default: begin
               status_in = srct_pkg::STATUS_OK;
            end
         endcase
      end
   end

   // Table registers: valid bits reset, payload written on demand
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      rank_ff <= rank_in;
      for (int i = 0; i < ENTRIES; i++) begin
         if (new_we[i]) begin
            low_ff[i]   <= addr_ff;
            high_ff[i]  <= end_addr;
            owner_ff[i] <= '0;
         end else if (own_we[i]) begin
            owner_ff[i] <= own_wdata;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         status_ff    <= status_in;
         hit_ff       <= hit_in;
         slot_ff      <= slot_in;
         owner_out_ff <= owner_out_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_owner_thread = owner_out_ff;

endmodule

`default_nettype wire

[hw/rtl/srct_checker.sv]
`default_nettype none

// Port-level checks on the context table
module srct_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [srct_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_hit,
   input logic [srct_pkg::SLOT_W-1:0]   rsp_slot,
   input logic [srct_pkg::TID_W-1:0]    rsp_owner_thread
);

   // Every item taken gives a result on rsp_valid
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("item taken without a result two cycles later");

   // No result without an item taken before it
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a matching item");

   // A miss reports neither slot nor owner
   a_miss_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_slot == '0 && rsp_owner_thread == '0))
      else $error("miss with nonzero slot or owner");

   // Error status never comes with a hit
   a_error_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == srct_pkg::STATUS_INVALID
                     || rsp_status == srct_pkg::STATUS_FULL
                     || rsp_status == srct_pkg::STATUS_NO_MATCH)) |-> !rsp_hit)
      else $error("error status with hit set");

endmodule

bind stack_range_context_table_unit srct_checker u_srct_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_hit          (rsp_hit),
   .rsp_slot         (rsp_slot),
   .rsp_owner_thread (rsp_owner_thread)
);

`default_nettype wire
